>>> hw/rtl/ifsb_pkg.sv
// Shared constants, item types and helper functions of the inertial/camera sync buffer.
package ifsb_pkg;

  localparam int SAMPLE_DEPTH     = 32;
  localparam int FRAME_DEPTH      = 8;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int SAW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int FAW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int SCW = $clog2(SAMPLE_DEPTH + 1);
  localparam int FCW = $clog2(FRAME_DEPTH + 1);
  localparam int JW  = (SCW > FCW) ? SCW : FCW;
  localparam int WW  = WEIGHT_FRAC_BITS + 1;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_FRAME   = 2'd1,
    KIND_REQUEST = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_EMPTY     = 3'd0,
    ST_NO_EARLY  = 3'd1,
    ST_WAIT      = 3'd2,
    ST_TOO_FEW   = 3'd3,
    ST_DELIVERED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_IMU_RATE = 2'd0,
    REG_CAM_RATE = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [47:0]        stamp;
    logic signed [31:0] time_offset;
    logic [31:0]        interval;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic [15:0]        image_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         result_status;
    logic [15:0]        frame_tag;
    logic [47:0]        sample_time;
    logic [31:0]        sample_interval;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last_in_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [47:0] stamp;
    logic [31:0] interval;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
  } sample_t;

  typedef struct packed {
    logic [47:0] stamp;
    logic [15:0] tag;
  } frame_t;

  function automatic logic [31:0] sat32(logic [47:0] v);
    return (v[47:32] != 16'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] chan(sample_t s, logic [2:0] k);
    logic [31:0] v;
    case (k)
      3'd0:    v = s.gx;
      3'd1:    v = s.gy;
      3'd2:    v = s.gz;
      3'd3:    v = s.ax;
      3'd4:    v = s.ay;
      default: v = s.az;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/ifsb_if.sv
// Valid/ready channel interfaces for input items, result items and register writes.
interface ifsb_in_if;
  logic               valid;
  logic               ready;
  ifsb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ifsb_out_if;
  logic                valid;
  logic                ready;
  ifsb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ifsb_cfg_if;
  logic                valid;
  logic                ready;
  ifsb_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/ifsb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ifsb_ram #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                      wdata,
  input  logic                              re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                      rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ifsb_wdiv.sv
// Restoring divider for the interpolation weight, one quotient bit per cycle.
module ifsb_wdiv (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [47:0]             num,
  input  logic [47:0]             den,
  output logic                    done,
  output logic [ifsb_pkg::WW-1:0] wgt
);

  localparam int CW = $clog2(ifsb_pkg::WW + 1);

  logic                    busy_r;
  logic                    done_r;
  logic [CW-1:0]           cnt_r;
  logic [48:0]             rem_r;
  logic [47:0]             den_r;
  logic [ifsb_pkg::WW-1:0] q_r;
  logic [49:0]             shl;
  logic                    ge;
  logic [ifsb_pkg::WW:0]   qr;

  assign shl  = {rem_r, 1'b0};
  assign ge   = shl >= {2'b00, den_r};
  assign qr   = {1'b0, q_r} + 1'b1;
  assign wgt  = qr[ifsb_pkg::WW:1];
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ifsb_pkg::WW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 49'(shl - {2'b00, den_r}) : shl[48:0];
      q_r   <= {q_r[ifsb_pkg::WW-2:0], ge};
    end
  end

endmodule

>>> hw/rtl/imu_frame_sync_buffer.sv
// Top level: sorted sample and frame stores in RAM rings, request sequencer, output register.
// Push: an item is inserted in stamp order, moving later entries up one place at a time;
// a push to a full store is dropped. Drain: samples are read and handed out one at a time;
// interpolation then runs the divider and blends the six channels one after another on one
// multiplier, then emits the result. One item in work at a time; the output
// register lets the next item in while a result waits. Reset: both stores empty, 200/20 rates.
module imu_frame_sync_buffer (
  input  logic        clk,
  input  logic        rst_n,
  ifsb_in_if.sink     in_ch,
  ifsb_out_if.source  out_ch,
  ifsb_cfg_if.sink    cfg_ch
);

  localparam int SAW = ifsb_pkg::SAW;
  localparam int FAW = ifsb_pkg::FAW;
  localparam int SCW = ifsb_pkg::SCW;
  localparam int FCW = ifsb_pkg::FCW;
  localparam int JW  = ifsb_pkg::JW;
  localparam int F   = ifsb_pkg::WEIGHT_FRAC_BITS;
  localparam int BW  = F + 35;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_INS_RD   = 11'b00000000010,
    S_INS_CMP  = 11'b00000000100,
    S_RQ_HEAD  = 11'b00000001000,
    S_RQ_LAST  = 11'b00000010000,
    S_STAT     = 11'b00000100000,
    S_DR_RD    = 11'b00001000000,
    S_DR_CHK   = 11'b00010000000,
    S_DIV      = 11'b00100000000,
    S_MIX      = 11'b01000000000,
    S_EMIT_INT = 11'b10000000000
  } state_t;

  function automatic logic [SAW-1:0] s_phys(logic [SAW-1:0] h, logic [SCW-1:0] o);
    logic [SCW:0] s;
    s = (SCW+1)'(h) + (SCW+1)'(o);
    if (s >= (SCW+1)'(ifsb_pkg::SAMPLE_DEPTH)) begin
      s = s - (SCW+1)'(ifsb_pkg::SAMPLE_DEPTH);
    end
    return s[SAW-1:0];
  endfunction

  function automatic logic [FAW-1:0] f_phys(logic [FAW-1:0] h, logic [FCW-1:0] o);
    logic [FCW:0] s;
    s = (FCW+1)'(h) + (FCW+1)'(o);
    if (s >= (FCW+1)'(ifsb_pkg::FRAME_DEPTH)) begin
      s = s - (FCW+1)'(ifsb_pkg::FRAME_DEPTH);
    end
    return s[FAW-1:0];
  endfunction

  function automatic ifsb_pkg::out_item_t mk_out(ifsb_pkg::status_t st, logic [15:0] tag,
                                                 ifsb_pkg::sample_t s, logic last);
    ifsb_pkg::out_item_t o;
    o.result_status   = st;
    o.frame_tag       = tag;
    o.sample_time     = s.stamp;
    o.sample_interval = s.interval;
    o.rate_x          = s.gx;
    o.rate_y          = s.gy;
    o.rate_z          = s.gz;
    o.force_x         = s.ax;
    o.force_y         = s.ay;
    o.force_z         = s.az;
    o.last_in_run     = last;
    return o;
  endfunction

  state_t                  state_r, state_nxt;
  logic [SAW-1:0]          s_head_r, s_head_nxt;
  logic [SCW-1:0]          s_cnt_r, s_cnt_nxt;
  logic [FAW-1:0]          f_head_r, f_head_nxt;
  logic [FCW-1:0]          f_cnt_r, f_cnt_nxt;
  logic [15:0]             imu_rate_r, imu_rate_nxt;
  logic [9:0]              cam_rate_r, cam_rate_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [2:0]              k_r, k_nxt;

  ifsb_pkg::in_item_t      item_r, item_nxt;
  logic [JW-1:0]           j_r, j_nxt;
  logic                    ins_frame_r, ins_frame_nxt;
  logic signed [49:0]      target_r, target_nxt;
  logic [15:0]             tag_r, tag_nxt;
  logic                    late_r, late_nxt;
  logic                    few_r, few_nxt;
  ifsb_pkg::status_t       stat_r, stat_nxt;
  ifsb_pkg::sample_t       pend_r, pend_nxt;
  logic [5:0][31:0]        mix_r, mix_nxt;
  ifsb_pkg::out_item_t     out_r, out_nxt;

  logic                    s_we, s_re, f_we, f_re;
  logic [SAW-1:0]          s_waddr, s_raddr;
  logic [FAW-1:0]          f_waddr, f_raddr;
  ifsb_pkg::sample_t       s_wdata, s_rdata, new_s;
  ifsb_pkg::frame_t        f_wdata, f_rdata, new_f;

  logic                    div_start, div_done;
  logic [ifsb_pkg::WW-1:0] wgt;
  logic [47:0]             div_num, div_den;

  logic                    accept, slot_free, take;
  logic [9:0]              div_c;
  logic [SCW:0]            cnt1;
  logic [SCW+10:0]         need;
  logic signed [49:0]      target_c;
  logic [47:0]             rd_stamp;
  logic [31:0]             mix_a, mix_b;
  logic signed [32:0]      diff;
  logic signed [BW-1:0]    acc;
  ifsb_pkg::sample_t       interp, rewr;
  ifsb_pkg::sample_t       zero_s;

  ifsb_ram #(.W($bits(ifsb_pkg::sample_t)), .D(ifsb_pkg::SAMPLE_DEPTH)) u_sram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  ifsb_ram #(.W($bits(ifsb_pkg::frame_t)), .D(ifsb_pkg::FRAME_DEPTH)) u_fram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  ifsb_wdiv u_wdiv (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .wgt(wgt)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign zero_s   = '0;
  assign div_c    = (cam_rate_r == 10'd0) ? 10'd1 : cam_rate_r;
  assign cnt1     = {1'b0, s_cnt_r} + 1'b1;
  assign need     = (SCW+11)'(cnt1) * (SCW+11)'(div_c);
  assign target_c = $signed({2'b00, f_rdata.stamp}) + 50'(item_r.time_offset);
  assign rd_stamp = ins_frame_r ? f_rdata.stamp : s_rdata.stamp;
  assign take     = (s_cnt_r != '0) && ($signed({2'b00, s_rdata.stamp}) <= target_r);
  assign div_num  = s_rdata.stamp - target_r[47:0];
  assign div_den  = s_rdata.stamp - pend_r.stamp;

  assign mix_a = ifsb_pkg::chan(pend_r, k_r);
  assign mix_b = ifsb_pkg::chan(s_rdata, k_r);
  assign diff  = {mix_a[31], mix_a} - {mix_b[31], mix_b};
  assign acc   = BW'(diff) * BW'($signed({1'b0, wgt}))
               + (BW'($signed(mix_b)) <<< F)
               + (BW'(1) <<< (F - 1));

  always_comb begin
    new_s.stamp    = item_r.stamp;
    new_s.interval = item_r.interval;
    new_s.gx       = item_r.gyro_x;
    new_s.gy       = item_r.gyro_y;
    new_s.gz       = item_r.gyro_z;
    new_s.ax       = item_r.accel_x;
    new_s.ay       = item_r.accel_y;
    new_s.az       = item_r.accel_z;
    new_f.stamp    = item_r.stamp;
    new_f.tag      = item_r.image_tag;

    interp.stamp    = target_r[47:0];
    interp.interval = ifsb_pkg::sat32(target_r[47:0] - pend_r.stamp);
    interp.gx       = mix_r[0];
    interp.gy       = mix_r[1];
    interp.gz       = mix_r[2];
    interp.ax       = mix_r[3];
    interp.ay       = mix_r[4];
    interp.az       = mix_r[5];

    rewr          = s_rdata;
    rewr.interval = ifsb_pkg::sat32(s_rdata.stamp - target_r[47:0]);
  end

  always_comb begin
    state_nxt     = state_r;
    s_head_nxt    = s_head_r;
    s_cnt_nxt     = s_cnt_r;
    f_head_nxt    = f_head_r;
    f_cnt_nxt     = f_cnt_r;
    imu_rate_nxt  = imu_rate_r;
    cam_rate_nxt  = cam_rate_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pend_v_nxt    = pend_v_r;
    k_nxt         = k_r;
    item_nxt      = item_r;
    j_nxt         = j_r;
    ins_frame_nxt = ins_frame_r;
    target_nxt    = target_r;
    tag_nxt       = tag_r;
    late_nxt      = late_r;
    few_nxt       = few_r;
    stat_nxt      = stat_r;
    pend_nxt      = pend_r;
    mix_nxt       = mix_r;
    out_nxt       = out_r;
    s_we = 1'b0; s_re = 1'b0; f_we = 1'b0; f_re = 1'b0;
    s_waddr = s_head_r; s_raddr = s_head_r; s_wdata = new_s;
    f_waddr = f_head_r; f_raddr = f_head_r; f_wdata = new_f;
    div_start = 1'b0;

    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        ifsb_pkg::REG_IMU_RATE: imu_rate_nxt = cfg_ch.data.data;
        ifsb_pkg::REG_CAM_RATE: cam_rate_nxt = cfg_ch.data.data[9:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_ch.data;
          unique case (in_ch.data.kind)
            ifsb_pkg::KIND_SAMPLE: begin
              if (s_cnt_r != SCW'(ifsb_pkg::SAMPLE_DEPTH)) begin
                ins_frame_nxt = 1'b0;
                j_nxt         = JW'(s_cnt_r);
                state_nxt     = S_INS_RD;
              end
            end
            ifsb_pkg::KIND_FRAME: begin
              if (f_cnt_r != FCW'(ifsb_pkg::FRAME_DEPTH)) begin
                ins_frame_nxt = 1'b1;
                j_nxt         = JW'(f_cnt_r);
                state_nxt     = S_INS_RD;
              end
            end
            ifsb_pkg::KIND_REQUEST: begin
              if (s_cnt_r == '0 || f_cnt_r == '0) begin
                stat_nxt  = ifsb_pkg::ST_EMPTY;
                tag_nxt   = 16'd0;
                state_nxt = S_STAT;
              end else begin
                s_re      = 1'b1;
                f_re      = 1'b1;
                state_nxt = S_RQ_HEAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (j_r == '0) begin
          s_we = !ins_frame_r;
          f_we = ins_frame_r;
          if (ins_frame_r) begin
            f_cnt_nxt = f_cnt_r + 1'b1;
          end else begin
            s_cnt_nxt = s_cnt_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end else begin
          s_re      = !ins_frame_r;
          f_re      = ins_frame_r;
          s_raddr   = s_phys(s_head_r, SCW'(j_r - 1'b1));
          f_raddr   = f_phys(f_head_r, FCW'(j_r - 1'b1));
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        s_we    = !ins_frame_r;
        f_we    = ins_frame_r;
        s_waddr = s_phys(s_head_r, SCW'(j_r));
        f_waddr = f_phys(f_head_r, FCW'(j_r));
        if (rd_stamp > item_r.stamp) begin
          s_wdata   = s_rdata;
          f_wdata   = f_rdata;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          if (ins_frame_r) begin
            f_cnt_nxt = f_cnt_r + 1'b1;
          end else begin
            s_cnt_nxt = s_cnt_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RQ_HEAD: begin
        target_nxt = target_c;
        tag_nxt    = f_rdata.tag;
        late_nxt   = $signed({2'b00, s_rdata.stamp}) >= target_c;
        few_nxt    = need <= (SCW+11)'(imu_rate_r);
        s_re       = 1'b1;
        s_raddr    = s_phys(s_head_r, s_cnt_r - 1'b1);
        state_nxt  = S_RQ_LAST;
      end
      S_RQ_LAST: begin
        state_nxt = S_STAT;
        if (late_r) begin
          stat_nxt = ifsb_pkg::ST_NO_EARLY;
        end else if ($signed({2'b00, s_rdata.stamp}) < target_r) begin
          stat_nxt = ifsb_pkg::ST_WAIT;
        end else if (few_r) begin
          stat_nxt = ifsb_pkg::ST_TOO_FEW;
        end else begin
          pend_v_nxt = 1'b0;
          state_nxt  = S_DR_RD;
        end
        if (stat_nxt != ifsb_pkg::ST_WAIT || state_nxt == S_DR_RD) begin
          f_head_nxt = f_phys(f_head_r, FCW'(1));
          f_cnt_nxt  = f_cnt_r - 1'b1;
        end
      end
      S_STAT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(stat_r, tag_r, zero_s, 1'b1);
          state_nxt     = S_IDLE;
        end
      end
      S_DR_RD: begin
        s_re      = 1'b1;
        state_nxt = S_DR_CHK;
      end
      S_DR_CHK: begin
        if (take) begin
          if (!pend_v_r || slot_free) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_out(ifsb_pkg::ST_DELIVERED, tag_r, pend_r, 1'b0);
            end
            pend_nxt   = s_rdata;
            pend_v_nxt = 1'b1;
            s_head_nxt = s_phys(s_head_r, SCW'(1));
            s_cnt_nxt  = s_cnt_r - 1'b1;
            state_nxt  = S_DR_RD;
          end
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (s_cnt_r != '0 && $signed({2'b00, pend_r.stamp}) < target_r) begin
            out_nxt   = mk_out(ifsb_pkg::ST_DELIVERED, tag_r, pend_r, 1'b0);
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            out_nxt   = mk_out(ifsb_pkg::ST_DELIVERED, tag_r, pend_r, 1'b1);
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          k_nxt     = 3'd0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        mix_nxt[k_r] = acc[F+31:F];
        k_nxt        = k_r + 1'b1;
        if (k_r == 3'd5) begin
          state_nxt = S_EMIT_INT;
        end
      end
      S_EMIT_INT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(ifsb_pkg::ST_DELIVERED, tag_r, interp, 1'b1);
          s_we          = 1'b1;
          s_wdata       = rewr;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      s_head_r    <= '0;
      s_cnt_r     <= '0;
      f_head_r    <= '0;
      f_cnt_r     <= '0;
      imu_rate_r  <= 16'd200;
      cam_rate_r  <= 10'd20;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      s_head_r    <= s_head_nxt;
      s_cnt_r     <= s_cnt_nxt;
      f_head_r    <= f_head_nxt;
      f_cnt_r     <= f_cnt_nxt;
      imu_rate_r  <= imu_rate_nxt;
      cam_rate_r  <= cam_rate_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    j_r         <= j_nxt;
    ins_frame_r <= ins_frame_nxt;
    target_r    <= target_nxt;
    tag_r       <= tag_nxt;
    late_r      <= late_nxt;
    few_r       <= few_nxt;
    stat_r      <= stat_nxt;
    pend_r      <= pend_nxt;
    mix_r       <= mix_nxt;
    out_r       <= out_nxt;
  end

endmodule

>>> tb/sv/testbench.sv
// Testbench for imu_frame_sync_buffer: directed and random pushes/requests checked by a scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;

  class frame_pairing_model;
    bit [47:0] s_time[ifsb_pkg::SAMPLE_DEPTH];
    bit [31:0] s_iv[ifsb_pkg::SAMPLE_DEPTH];
    bit [31:0] s_val[ifsb_pkg::SAMPLE_DEPTH][6];
    int        s_n;
    bit [47:0] f_time[ifsb_pkg::FRAME_DEPTH];
    bit [15:0] f_tag[ifsb_pkg::FRAME_DEPTH];
    int        f_n;
    bit [15:0] imu_rate;
    bit [9:0]  cam_rate;
    ifsb_pkg::out_item_t expected_results[$];
    int        mismatches;
    int        status_seen[5];

    function new();
      s_n = 0;
      f_n = 0;
      imu_rate = 200;
      cam_rate = 20;
      mismatches = 0;
    endfunction

    function void write_reg(ifsb_pkg::reg_index_t idx, bit [15:0] data);
      if (idx == ifsb_pkg::REG_IMU_RATE) imu_rate = data;
      else if (idx == ifsb_pkg::REG_CAM_RATE) cam_rate = data[9:0];
    endfunction

    function void add_expected(ifsb_pkg::out_item_t r);
      expected_results.insert(expected_results.size(), r);
    endfunction

    function ifsb_pkg::out_item_t status_only(ifsb_pkg::status_t st, bit [15:0] tag);
      ifsb_pkg::out_item_t r;
      r = '0;
      r.result_status = st;
      r.frame_tag = tag;
      return r;
    endfunction

    function bit [31:0] sat32(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function longint unsigned interp_weight(longint unsigned num, longint unsigned den);
      longint unsigned rem, q;
      rem = num;
      q = 0;
      repeat (ifsb_pkg::WEIGHT_FRAC_BITS + 1) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q = q | 1;
        end
      end
      return (q + 1) >> 1;
    endfunction

    function bit [31:0] blend(bit [31:0] a, bit [31:0] b, longint w);
      longint acc;
      acc = longint'($signed(a)) * w
          + longint'($signed(b)) * ((longint'(1) << ifsb_pkg::WEIGHT_FRAC_BITS) - w);
      acc = (acc + (longint'(1) << (ifsb_pkg::WEIGHT_FRAC_BITS - 1)))
            >>> ifsb_pkg::WEIGHT_FRAC_BITS;
      return acc[31:0];
    endfunction

    function ifsb_pkg::out_item_t sample_result(bit [15:0] tag, bit [47:0] t, bit [31:0] iv,
                                                bit [31:0] v[6]);
      ifsb_pkg::out_item_t r;
      r = status_only(ifsb_pkg::ST_DELIVERED, tag);
      r.sample_time = t;
      r.sample_interval = iv;
      r.rate_x = v[0];
      r.rate_y = v[1];
      r.rate_z = v[2];
      r.force_x = v[3];
      r.force_y = v[4];
      r.force_z = v[5];
      return r;
    endfunction

    function void pop_sample();
      for (int i = 0; i < ifsb_pkg::SAMPLE_DEPTH - 1; i++) begin
        s_time[i] = s_time[i+1];
        s_iv[i] = s_iv[i+1];
        s_val[i] = s_val[i+1];
      end
      s_n--;
    endfunction

    function void pop_frame();
      for (int i = 0; i < ifsb_pkg::FRAME_DEPTH - 1; i++) begin
        f_time[i] = f_time[i+1];
        f_tag[i] = f_tag[i+1];
      end
      f_n--;
    endfunction

    function void serve_request(longint offset);
      bit [15:0]           tag;
      longint              target;
      int                  quota;
      longint unsigned     last_t, t2, tg, w;
      bit [31:0]           last_v[6];
      bit [31:0]           mix[6];
      ifsb_pkg::out_item_t r;
      if (s_n == 0 || f_n == 0) begin
        r = status_only(ifsb_pkg::ST_EMPTY, 16'd0);
        r.last_in_run = 1'b1;
        add_expected(r);
        return;
      end
      tag = f_tag[0];
      target = longint'(f_time[0]) + offset;
      quota = imu_rate / ((cam_rate == 0) ? 1 : cam_rate);
      if (longint'(s_time[0]) >= target) begin
        pop_frame();
        r = status_only(ifsb_pkg::ST_NO_EARLY, tag);
      end else if (longint'(s_time[s_n-1]) < target) begin
        r = status_only(ifsb_pkg::ST_WAIT, tag);
      end else if (s_n < quota) begin
        pop_frame();
        r = status_only(ifsb_pkg::ST_TOO_FEW, tag);
      end else begin
        pop_frame();
        last_t = 0;
        while (s_n > 0 && longint'(s_time[0]) <= target) begin
          add_expected(sample_result(tag, s_time[0], s_iv[0], s_val[0]));
          last_t = s_time[0];
          last_v = s_val[0];
          pop_sample();
        end
        if (longint'(last_t) < target && s_n > 0) begin
          t2 = s_time[0];
          tg = target;
          w = interp_weight(t2 - tg, t2 - last_t);
          for (int k = 0; k < 6; k++) mix[k] = blend(last_v[k], s_val[0][k], w);
          add_expected(sample_result(tag,
            (tg > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : tg[47:0],
            sat32(tg - last_t), mix));
          s_iv[0] = sat32(t2 - tg);
        end
        expected_results[$].last_in_run = 1'b1;
        return;
      end
      r.last_in_run = 1'b1;
      add_expected(r);
    endfunction

    function void accept_item(ifsb_pkg::in_item_t it);
      int pos;
      case (ifsb_pkg::kind_t'(it.kind))
        ifsb_pkg::KIND_SAMPLE: begin
          if (s_n < ifsb_pkg::SAMPLE_DEPTH) begin
            pos = 0;
            while (pos < s_n && s_time[pos] <= it.stamp) pos++;
            for (int i = s_n; i > pos; i--) begin
              s_time[i] = s_time[i-1];
              s_iv[i] = s_iv[i-1];
              s_val[i] = s_val[i-1];
            end
            s_time[pos] = it.stamp;
            s_iv[pos] = it.interval;
            s_val[pos] = '{it.gyro_x, it.gyro_y, it.gyro_z, it.accel_x, it.accel_y, it.accel_z};
            s_n++;
          end
        end
        ifsb_pkg::KIND_FRAME: begin
          if (f_n < ifsb_pkg::FRAME_DEPTH) begin
            pos = 0;
            while (pos < f_n && f_time[pos] <= it.stamp) pos++;
            for (int i = f_n; i > pos; i--) begin
              f_time[i] = f_time[i-1];
              f_tag[i] = f_tag[i-1];
            end
            f_time[pos] = it.stamp;
            f_tag[pos] = it.image_tag;
            f_n++;
          end
        end
        ifsb_pkg::KIND_REQUEST: serve_request(longint'($signed(it.time_offset)));
        default: ;
      endcase
    endfunction

    function void check_result(ifsb_pkg::out_item_t got);
      ifsb_pkg::out_item_t want;
      bit                  bad;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      bad = (got.result_status !== want.result_status) || (got.frame_tag !== want.frame_tag)
         || (got.sample_time !== want.sample_time)
         || (got.sample_interval !== want.sample_interval)
         || (got.rate_x !== want.rate_x) || (got.rate_y !== want.rate_y)
         || (got.rate_z !== want.rate_z) || (got.force_x !== want.force_x)
         || (got.force_y !== want.force_y) || (got.force_z !== want.force_z)
         || (got.last_in_run !== want.last_in_run);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
      if (want.result_status <= ifsb_pkg::ST_DELIVERED) status_seen[want.result_status]++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ifsb_in_if  in_ch();
  ifsb_out_if out_ch();
  ifsb_cfg_if cfg_ch();

  imu_frame_sync_buffer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_pairing_model model = new();
  int     items_sent;
  int     results_seen;
  int     hold_left;
  int     quiet = 0;
  bit     steady_in;
  longint head;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("imu_frame_sync_buffer test failed");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    results_seen = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (!(results_seen >= 100 && results_seen < 180) && $urandom_range(99) < 34) begin
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        model.check_result(out_ch.data);
        results_seen++;
        if (results_seen == 40) hold_left = 400;
      end
    end
  end

  task automatic send(ifsb_pkg::in_item_t it);
    while (!steady_in && $urandom_range(99) < 34) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    model.accept_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(ifsb_pkg::reg_index_t idx, bit [15:0] data);
    in_ch.valid = 1'b0;
    cfg_ch.valid = 1'b1;
    cfg_ch.data.index = idx;
    cfg_ch.data.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (model.expected_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic ifsb_pkg::in_item_t make_item(ifsb_pkg::kind_t k, bit [47:0] stamp,
                                                   bit [31:0] off, bit [15:0] tag,
                                                   bit [31:0] v);
    ifsb_pkg::in_item_t it;
    it.kind = k;
    it.stamp = stamp;
    it.time_offset = off;
    it.interval = v;
    it.gyro_x = v;
    it.gyro_y = v;
    it.gyro_z = v;
    it.accel_x = v;
    it.accel_y = v;
    it.accel_z = v;
    it.image_tag = tag;
    return it;
  endfunction

  function automatic ifsb_pkg::in_item_t random_item(int req_pct);
    ifsb_pkg::in_item_t it;
    int                 pick;
    longint             tgt, off, lo, span;
    it = make_item(ifsb_pkg::KIND_SAMPLE, 48'd0, $urandom, $urandom, $urandom);
    it.gyro_y = $urandom;
    it.gyro_z = $urandom;
    it.accel_x = $urandom;
    it.accel_y = $urandom;
    it.accel_z = $urandom;
    it.interval = $urandom;
    pick = $urandom_range(99);
    if (pick < req_pct) begin
      it.kind = ifsb_pkg::KIND_REQUEST;
      if (model.s_n > 0 && model.f_n > 0 && $urandom_range(99) < 80) begin
        lo = longint'(model.s_time[0]) - 50;
        span = longint'(model.s_time[model.s_n-1]) - lo + 50;
        if (span < 64'd2000000000) begin
          tgt = lo + $urandom_range(span);
          off = tgt - longint'(model.f_time[0]);
          if (off >= -64'sd2147483648 && off <= 64'sd2147483647) it.time_offset = off[31:0];
        end
      end
    end else if (pick < req_pct + 8) begin
      it.kind = ifsb_pkg::kind_t'($urandom_range(3));
      it.stamp = head[47:0] + $urandom_range(500);
    end else if (pick < req_pct + 25) begin
      it.kind = ifsb_pkg::KIND_FRAME;
      tgt = head + $urandom_range(1500) - 1000;
      it.stamp = (tgt < 0) ? 48'd0 : tgt[47:0];
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        tgt = head - $urandom_range(600);
        it.stamp = (tgt < 0) ? 48'd0 : tgt[47:0];
      end else if (pick < 15) begin
        it.stamp = head[47:0];
      end else begin
        head = head + $urandom_range(1, 400);
        it.stamp = head[47:0];
      end
    end
    return it;
  endfunction

  task automatic random_phase(bit [15:0] imu, bit [15:0] cam, int count, int req_pct);
    settle();
    write_reg(ifsb_pkg::REG_IMU_RATE, imu);
    write_reg(ifsb_pkg::REG_CAM_RATE, cam);
    for (int i = 0; i < count; i++) begin
      steady_in = (i >= 20 && i < 50);
      send(random_item(req_pct));
    end
    steady_in = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    items_sent = 0;
    steady_in = 1'b0;
    head = 3000;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(make_item(ifsb_pkg::KIND_REQUEST, 48'd0, 32'd0, 16'd0, 32'd0));
    send(make_item(ifsb_pkg::KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                   32'hFFFF_FFFF));
    send(make_item(ifsb_pkg::KIND_SAMPLE, 48'd0, 32'd0, 16'd0, 32'h7FFF_FFFF));
    send(make_item(ifsb_pkg::KIND_FRAME, 48'd0, 32'd0, 16'hFFFF, 32'd0));
    send(make_item(ifsb_pkg::KIND_REQUEST, 48'd0, 32'd0, 16'd0, 32'd0));
    send(make_item(ifsb_pkg::KIND_FRAME, 48'd1000, 32'd0, 16'd1, 32'd0));
    send(make_item(ifsb_pkg::KIND_REQUEST, 48'd0, 32'h8000_0000, 16'd0, 32'd0));
    send(make_item(ifsb_pkg::KIND_FRAME, 48'd1000, 32'd0, 16'd2, 32'd0));
    send(make_item(ifsb_pkg::KIND_SAMPLE, 48'd500, 32'd0, 16'd0, 32'h8000_0000));
    send(make_item(ifsb_pkg::KIND_SAMPLE, 48'd500, 32'd0, 16'd0, 32'd12345));
    send(make_item(ifsb_pkg::KIND_REQUEST, 48'd0, 32'h7FFF_FFFF, 16'd0, 32'd0));
    send(make_item(ifsb_pkg::KIND_SAMPLE, 48'd2000, 32'd0, 16'd0, 32'h8000_0000));
    send(make_item(ifsb_pkg::KIND_REQUEST, 48'd0, 32'd0, 16'd0, 32'd0));
    settle();
    write_reg(ifsb_pkg::REG_IMU_RATE, 16'd1);
    write_reg(ifsb_pkg::REG_CAM_RATE, 16'd1);
    send(make_item(ifsb_pkg::KIND_SAMPLE, 48'hFFFF_FFFF_FFFF, 32'd0, 16'd0, 32'h7FFF_FFFF));
    send(make_item(ifsb_pkg::KIND_FRAME, 48'h4_0000_0000, 32'd0, 16'd3, 32'd0));
    send(make_item(ifsb_pkg::KIND_REQUEST, 48'd0, 32'd0, 16'd0, 32'd0));
    send(make_item(ifsb_pkg::KIND_SAMPLE, 48'hFFFF_FFFF_FFF5, 32'd0, 16'd0, 32'hFFFF_FFFF));
    send(make_item(ifsb_pkg::KIND_FRAME, 48'hFFFF_FFFF_FFFF, 32'd0, 16'd4, 32'd0));
    send(make_item(ifsb_pkg::KIND_REQUEST, 48'd0, 32'd0, 16'd0, 32'd0));

    random_phase(16'd1, 16'd1, 130, 30);
    random_phase(16'd200, 16'd20, 80, 30);
    random_phase(16'hFFFF, 16'd1000, 60, 5);
    random_phase(16'd7, 16'd0, 90, 30);
    settle();

    $display("sent %0d items over five rate settings, including full stores and a long stall",
             items_sent);
    $display("results: %0d empty, %0d no-early, %0d waiting, %0d too-few, %0d samples",
             model.status_seen[0], model.status_seen[1], model.status_seen[2],
             model.status_seen[3], model.status_seen[4]);
    if (model.mismatches == 0 && model.expected_results.size() == 0) begin
      $display("imu_frame_sync_buffer test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", model.mismatches,
               model.expected_results.size());
      $display("imu_frame_sync_buffer test failed");
    end
    $finish;
  end

endmodule
